@@ rtl/ids_pkg.sv @@
package ids_pkg;

	localparam int STACK_DEPTH = 128;
	localparam int COLUMN_BITS = 16;
	localparam int LEVEL_BITS  = $clog2(STACK_DEPTH);

	localparam int S_TDATA_BITS = 24;
	localparam int M_TDATA_BITS = 8;
	localparam int M_TUSER_BITS = 2;

	localparam int IN_NEWLINE_BIT = 0;
	localparam int IN_COLUMN_LSB  = 1;
	localparam int IN_INDENT_BIT  = 17;
	localparam int IN_DEDENT_BIT  = 18;
	localparam int IN_LEFT_BIT    = 19;

	typedef logic [COLUMN_BITS-1:0] column_t;
	typedef logic [LEVEL_BITS-1:0]  level_t;
	typedef logic [1:0]             kind_t;

	localparam kind_t KIND_INDENT       = 2'd0;
	localparam kind_t KIND_DEDENT       = 2'd1;
	localparam kind_t KIND_LEFT_ALIGNED = 2'd2;

	localparam level_t LEVEL_MAX = level_t'(STACK_DEPTH - 1);

endpackage

@@ rtl/ids_ram.sv @@
module ids_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/indent_dedent_layout_scanner_core.sv @@
// Layout scanner keeping a Python-style stack of indentation columns in one
// synchronous RAM; the top column is also held in a register. One result per
// request. A request passes through an accept state and a decide state; a dedent
// then reloads the new top column from the RAM in a further state. A line whose
// column falls below the top entry first scans the stack downward, one RAM read
// per cycle, reading from 1 up to the current level of entries. The single RAM
// read port sets these steps. Entry 0 always reads as column zero, so the RAM
// needs no clearing after reset.
// s_tdata fields from bit 0: newline_seen[0], column[16:1], allow_indent[17],
// allow_dedent[18], allow_left_aligned[19], zero fill [23:20].
// m_tdata: token_found[0], zero fill [7:1]. m_tuser: token_kind[1:0].
module indent_dedent_layout_scanner_core
	import ids_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [S_TDATA_BITS-1:0] s_tdata,   // newline_seen, column, allow_indent,
	                                           // allow_dedent, allow_left_aligned
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [M_TDATA_BITS-1:0] m_tdata,   // token_found
	output logic [M_TUSER_BITS-1:0] m_tuser    // token_kind
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_TOP  = 2'd3;

	logic [1:0] state_q;
	level_t     level_q;
	level_t     pend_q;
	logic       at_ls_q;
	column_t    top_q;
	level_t     idx_q;
	column_t    col_q;
	logic       al_ind_q;
	logic       al_ded_q;
	logic       al_left_q;
	logic       m_tvalid_q;
	logic       found_q;
	kind_t      kind_q;

	logic    in_nl;
	column_t in_col;
	logic    out_free;
	logic    do_dedent;
	logic    do_left;
	logic    do_indent;
	column_t scan_val;
	logic    we;
	level_t  waddr;
	level_t  raddr;
	column_t rdata;

	assign in_nl  = s_tdata[IN_NEWLINE_BIT];
	assign in_col = s_tdata[IN_COLUMN_LSB +: COLUMN_BITS];

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_BITS-1){1'b0}}, found_q};
	assign m_tuser  = kind_q;

	assign out_free  = !m_tvalid_q || m_tready;
	assign do_dedent = al_ded_q && (level_q != '0) && (pend_q != '0);
	assign do_left   = !do_dedent && al_left_q && at_ls_q && (col_q == top_q);
	assign do_indent = !do_dedent && !do_left && al_ind_q && at_ls_q && (col_q > top_q)
	                   && (level_q != LEVEL_MAX);
	assign scan_val  = (idx_q == '0) ? '0 : rdata;
	assign waddr     = level_q + 1'b1;

	always_comb begin
		raddr = level_q - 1'b1;
		we    = 1'b0;
		case (state_q)
			ST_SCAN: begin
				raddr = idx_q - 1'b1;
			end
			ST_DONE: begin
				we = out_free && do_indent;
			end
			default: begin
				raddr = level_q - 1'b1;
			end
		endcase
	end

	ids_ram #(
		.WIDTH(COLUMN_BITS),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(col_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			level_q    <= '0;
			pend_q     <= '0;
			at_ls_q    <= 1'b1;
			top_q      <= '0;
			idx_q      <= '0;
			col_q      <= '0;
			al_ind_q   <= 1'b0;
			al_ded_q   <= 1'b0;
			al_left_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			kind_q     <= KIND_INDENT;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						col_q     <= in_col;
						al_ind_q  <= s_tdata[IN_INDENT_BIT];
						al_ded_q  <= s_tdata[IN_DEDENT_BIT];
						al_left_q <= s_tdata[IN_LEFT_BIT];
						at_ls_q   <= at_ls_q || in_nl;
						if (in_nl) begin
							pend_q <= '0;
						end
						if ((at_ls_q || in_nl) && (in_nl || pend_q == '0) && (in_col < top_q)) begin
							idx_q   <= level_q - 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					if (scan_val == col_q) begin
						pend_q  <= level_q - idx_q;
						state_q <= ST_DONE;
					end else if (scan_val < col_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (do_dedent) begin
							level_q <= level_q - 1'b1;
							pend_q  <= pend_q - 1'b1;
							found_q <= 1'b1;
							kind_q  <= KIND_DEDENT;
							state_q <= ST_TOP;
						end else if (do_left) begin
							at_ls_q <= 1'b0;
							found_q <= 1'b1;
							kind_q  <= KIND_LEFT_ALIGNED;
							state_q <= ST_IDLE;
						end else if (do_indent) begin
							level_q <= level_q + 1'b1;
							top_q   <= col_q;
							found_q <= 1'b1;
							kind_q  <= KIND_INDENT;
							state_q <= ST_IDLE;
						end else begin
							at_ls_q <= 1'b0;
							found_q <= 1'b0;
							kind_q  <= KIND_INDENT;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TOP: begin
					top_q   <= (level_q == '0) ? '0 : rdata;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/sv/indent_dedent_layout_scanner_core_tb.sv @@
`timescale 1ns / 1ps

module indent_dedent_layout_scanner_core_tb;
	import ids_pkg::*;

	localparam int RANDOM_ITEMS = 1630;
	localparam int HOLD_START   = 2500;
	localparam int HOLD_LEN     = 400;
	localparam int DRAIN_CYCLES = 300;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic    newline;
		column_t column;
		logic    allow_indent;
		logic    allow_dedent;
		logic    allow_left;
	} layout_req_t;

	typedef struct packed {
		logic  found;
		kind_t kind;
	} token_t;

	typedef struct packed {
		layout_req_t req;
		logic        typed;
		token_t      want;
	} dir_row_t;

	localparam token_t NO_TOKEN = '{1'b0, KIND_INDENT};

	logic                    clk;
	logic                    arst_n;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata;
	logic                    m_tvalid;
	logic                    m_tready;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic [M_TUSER_BITS-1:0] m_tuser;

	column_t col_stack [STACK_DEPTH];
	int      lvl;
	int      dedents_owed;
	bit      line_start;

	token_t  expected_tokens [$];
	dir_row_t dir_rows [15];

	int failures;
	int burst_left;
	int requests_sent;
	int deepest;
	int indents_seen;
	int dedents_seen;
	int lefts_seen;
	int blanks_seen;

	indent_dedent_layout_scanner_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic token_t scan_layout(input layout_req_t r);
		column_t top;
		token_t  tok;
		bit      hit;
		top = col_stack[lvl];
		tok = NO_TOKEN;
		hit = 1'b0;
		if (r.newline) begin
			line_start = 1'b1;
			dedents_owed = 0;
		end
		if (line_start && dedents_owed == 0 && r.column < top) begin
			for (int i = 0; i <= lvl; i++) begin
				if (!hit && col_stack[i] == r.column) begin
					hit = 1'b1;
					dedents_owed = lvl - i;
				end
			end
		end
		if (r.allow_dedent && lvl > 0 && dedents_owed > 0) begin
			col_stack[lvl] = '0;
			lvl--;
			dedents_owed--;
			tok = '{1'b1, KIND_DEDENT};
		end else if (r.allow_left && line_start && r.column == top) begin
			line_start = 1'b0;
			tok = '{1'b1, KIND_LEFT_ALIGNED};
		end else if (r.allow_indent && line_start && r.column > top &&
			lvl < STACK_DEPTH - 1) begin
			lvl++;
			col_stack[lvl] = r.column;
			tok = '{1'b1, KIND_INDENT};
		end else begin
			line_start = 1'b0;
		end
		return tok;
	endfunction

	function automatic void note_failure(input string what, input token_t want, input token_t got);
		failures++;
		if (failures <= REPORT_LIMIT)
			$display("%0t: %s: expected found=%0b kind=%0d, got found=%0b kind=%0d",
				$realtime, what, want.found, want.kind, got.found, got.kind);
	endfunction

	task automatic offer(input layout_req_t r, input bit typed, input token_t typed_want);
		token_t                  want;
		logic [S_TDATA_BITS-1:0] d;
		d = '0;
		d[IN_NEWLINE_BIT] = r.newline;
		d[IN_COLUMN_LSB +: COLUMN_BITS] = r.column;
		d[IN_INDENT_BIT] = r.allow_indent;
		d[IN_DEDENT_BIT] = r.allow_dedent;
		d[IN_LEFT_BIT] = r.allow_left;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		want = scan_layout(r);
		if (typed)
			want = typed_want;
		expected_tokens.push_back(want);
		requests_sent++;
		if (lvl > deepest)
			deepest = lvl;
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 20);
		end
	endtask

	always @(posedge clk) begin
		token_t got;
		token_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[0], kind_t'(m_tuser)};
			if (!got.found)
				blanks_seen++;
			else if (got.kind == KIND_INDENT)
				indents_seen++;
			else if (got.kind == KIND_DEDENT)
				dedents_seen++;
			else
				lefts_seen++;
			if (expected_tokens.size() == 0) begin
				note_failure("unexpected result", NO_TOKEN, got);
			end else begin
				want = expected_tokens.pop_front();
				if (m_tdata != M_TDATA_BITS'(want.found) || m_tuser != want.kind)
					note_failure("result mismatch", want, got);
			end
		end
	end

	initial begin : receiver
		int cyc;
		int seg_left;
		int mode;
		cyc = 0;
		seg_left = 0;
		mode = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (seg_left == 0) begin
				seg_left = $urandom_range(1, 40);
				mode = $urandom_range(0, 2);
			end
			seg_left--;
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_LEN)
				m_tready <= 1'b0;
			else case (mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	initial begin
		#10ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		layout_req_t r;
		column_t     top;
		int          c;
		int          pick;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		failures = 0;
		requests_sent = 0;
		deepest = 0;
		indents_seen = 0;
		dedents_seen = 0;
		lefts_seen = 0;
		blanks_seen = 0;
		burst_left = 8;
		for (int i = 0; i < STACK_DEPTH; i++)
			col_stack[i] = '0;
		lvl = 0;
		dedents_owed = 0;
		line_start = 1'b1;

		dir_rows = '{
			'{'{1'b0, 16'd0,     1'b0, 1'b0, 1'b0}, 1'b1, NO_TOKEN},
			'{'{1'b1, 16'd0,     1'b0, 1'b0, 1'b1}, 1'b1, '{1'b1, KIND_LEFT_ALIGNED}},
			'{'{1'b1, 16'd4,     1'b1, 1'b0, 1'b0}, 1'b1, '{1'b1, KIND_INDENT}},
			'{'{1'b1, 16'd8,     1'b1, 1'b0, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'd8,     1'b0, 1'b0, 1'b1}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'd0,     1'b0, 1'b1, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b0, 16'd0,     1'b0, 1'b1, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b0, 16'd0,     1'b0, 1'b0, 1'b1}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'hFFFF,  1'b1, 1'b0, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'd3,     1'b0, 1'b1, 1'b1}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'hFFFF,  1'b1, 1'b1, 1'b1}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'd0,     1'b0, 1'b0, 1'b1}, 1'b0, NO_TOKEN},
			'{'{1'b0, 16'd0,     1'b0, 1'b1, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b0, 16'd5,     1'b1, 1'b0, 1'b0}, 1'b0, NO_TOKEN},
			'{'{1'b1, 16'hFFFF,  1'b0, 1'b0, 1'b0}, 1'b1, NO_TOKEN}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

		// fill the stack, try one push too many, then unwind to column zero
		while (lvl < STACK_DEPTH - 1) begin
			r = '{1'b1, column_t'(col_stack[lvl] + 3), 1'b1, 1'b0, 1'b0};
			offer(r, 1'b0, NO_TOKEN);
		end
		r = '{1'b1, 16'd60000, 1'b1, 1'b0, 1'b1};
		offer(r, 1'b0, NO_TOKEN);
		r = '{1'b1, 16'd0, 1'b0, 1'b1, 1'b0};
		offer(r, 1'b0, NO_TOKEN);
		while (dedents_owed > 0) begin
			r = '{1'b0, 16'd0, 1'b0, 1'b1, 1'b0};
			offer(r, 1'b0, NO_TOKEN);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			top = col_stack[lvl];
			if (dedents_owed > 0 && $urandom_range(0, 99) < 80) begin
				r.newline = 1'b0;
				r.column = column_t'($urandom());
				r.allow_indent = 1'($urandom_range(0, 1));
				r.allow_dedent = 1'b1;
				r.allow_left = 1'($urandom_range(0, 1));
			end else begin
				r.newline = ($urandom_range(0, 99) < 85);
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					c = int'(top) + $urandom_range(1, 8);
					if (c > 65535)
						c = 65535;
				end else if (pick < 55)
					c = int'(top);
				else if (pick < 80)
					c = int'(col_stack[$urandom_range(0, lvl)]);
				else if (pick < 90)
					c = int'($urandom_range(0, 65535));
				else
					c = (top == 0) ? 0 : int'(top) - 1;
				r.column = column_t'(c);
				r.allow_indent = ($urandom_range(0, 99) < 85);
				r.allow_dedent = ($urandom_range(0, 99) < 85);
				r.allow_left = ($urandom_range(0, 99) < 85);
			end
			offer(r, 1'b0, NO_TOKEN);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (expected_tokens.size() != 0)
			note_failure("missing result", expected_tokens.pop_front(), NO_TOKEN);

		$display("Sent %0d layout requests, stack depth up to %0d (full stack included)",
			requests_sent, deepest);
		$display("Results: %0d indents, %0d dedents, %0d left-aligned, %0d without token",
			indents_seen, dedents_seen, lefts_seen, blanks_seen);
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
